/* design/wpfs_pkg.sv */
package wpfs_pkg;

  // input commands
  typedef enum logic [1:0] {
    CMD_LOAD_GEOM = 2'd0,
    CMD_LOAD_BOX  = 2'd1,
    CMD_QUERY     = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_e;

  // what the shared serial multiplier is currently working for
  localparam logic [1:0] MODE_GEOM = 2'd0;
  localparam logic [1:0] MODE_ROW  = 2'd1;
  localparam logic [1:0] MODE_COL  = 2'd2;

  // geometry product sequence for one frame
  localparam logic [3:0] OP_EXEX = 4'd0;
  localparam logic [3:0] OP_EYEY = 4'd1;
  localparam logic [3:0] OP_LXLX = 4'd2;
  localparam logic [3:0] OP_LYLY = 4'd3;
  localparam logic [3:0] OP_PXEX = 4'd4;
  localparam logic [3:0] OP_PYEY = 4'd5;
  localparam logic [3:0] OP_PXEY = 4'd6;
  localparam logic [3:0] OP_PYEX = 4'd7;
  localparam logic [3:0] OP_DOTW = 4'd8;
  localparam logic [3:0] OP_CRSH = 4'd9;
  localparam logic [3:0] OP_XX   = 4'd10;
  localparam logic [3:0] OP_L2H2 = 4'd11;

endpackage

/* design/world_to_pixel_frame_search_top.sv */
// channel  | direction | handshake          | beat
// command  | in        | start_i / busy_o   | command_i, slot_i, a_x_i .. c_y_i, pixel_*_i
// result   | out       | done_o (strobe)    | found_o, box_hit_o, frame_index_o, row_o, col_o
// config   | in        | cfg_we_i           | cfg_wdata_i (frames_in_use)
//
// loads give no result; a query keeps busy_o high through ST_READ, ST_CHECK and ST_NEXT
// for each frame whose box misses and through the result cycle, and a box hit adds the work of
// the bit-serial multiplier (one multiplier bit per cycle over 12 products and 34 trials).
// the frame table lives in two memories, each with one write port and a registered read port.
// reset clears control state and frames_in_use; table contents stay undefined until loaded.
// the result beat is shown for one cycle and cannot be stalled; busy_o stays high until then.
module world_to_pixel_frame_search_top
  import wpfs_pkg::*;
#(
  parameter int MAX_FRAMES = 1024,
  parameter int COORD_BITS = 40,
  parameter int PIXEL_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   command_i,
  input  logic [9:0]                   slot_i,
  input  logic signed [COORD_BITS-1:0] a_x_i,
  input  logic signed [COORD_BITS-1:0] a_y_i,
  input  logic signed [COORD_BITS-1:0] b_x_i,
  input  logic signed [COORD_BITS-1:0] b_y_i,
  input  logic signed [COORD_BITS-1:0] c_x_i,
  input  logic signed [COORD_BITS-1:0] c_y_i,
  input  logic [PIXEL_BITS-1:0]        pixel_width_i,
  input  logic [PIXEL_BITS-1:0]        pixel_height_i,
  input  logic                         cfg_we_i,
  input  logic [10:0]                  cfg_wdata_i,
  output logic                         done_o,
  output logic                         found_o,
  output logic                         box_hit_o,
  output logic [9:0]                   frame_index_o,
  output logic [PIXEL_BITS-1:0]        row_o,
  output logic [PIXEL_BITS-1:0]        col_o
);

  localparam int FA   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNTW = $clog2(MAX_FRAMES + 1);
  localparam int CW1  = COORD_BITS + 1;
  localparam int DW   = 2 * CW1 + 1;
  localparam int NW   = DW + PIXEL_BITS;
  localparam int PW   = 2 * NW;
  localparam int AW   = PW + 2 * PIXEL_BITS + 2;
  localparam int QW   = PIXEL_BITS + 1;
  localparam int VW   = 2 * QW;
  localparam int KW   = $clog2(QW);
  localparam int GW   = 6 * COORD_BITS + 2 * PIXEL_BITS;
  localparam int BW   = 4 * COORD_BITS;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_SET   = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_QSET  = 3'd5;
  localparam logic [2:0] ST_NEXT  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  // frame table
  logic [GW-1:0] geo_mem [MAX_FRAMES];
  logic [BW-1:0] box_mem [MAX_FRAMES];
  logic [GW-1:0] geo_rd_q;
  logic [BW-1:0] box_rd_q;

  logic [2:0]      state_q;
  logic [10:0]     frames_in_use_q;
  logic [CNTW-1:0] count_q, n_q, count_d;
  logic signed [COORD_BITS-1:0] qx_q, qy_q;

  logic signed [CW1-1:0] px_q, py_q, ex_q, ey_q, lx_q, ly_q;
  logic [PIXEL_BITS-1:0] w_q, h_q;
  logic [DW-1:0] l2_q, h2_q, dot_q, crs_q;
  logic [NW-1:0] nrow_q, x_q;
  logic [PW-1:0] c_q, m_q;

  logic [3:0]    op_q;
  logic [1:0]    mode_q;
  logic [AW-1:0] ma_q, acc_q;
  logic [NW-1:0] mb_q;
  logic          neg_q;

  logic [QW-1:0] q_q, qr_q;
  logic [KW-1:0] k_q;

  logic                  found_q, hit_q;
  logic [CNTW-1:0]       idx_q;
  logic [PIXEL_BITS-1:0] row_q, col_q;

  logic accept, slot_ok, geo_we, box_we;
  logic [FA-1:0] wr_addr;

  assign accept  = start_i && !busy_o;
  assign slot_ok = 32'(slot_i) < 32'(MAX_FRAMES);
  assign wr_addr = FA'(slot_i);
  assign geo_we  = accept && (command_i == CMD_LOAD_GEOM) && slot_ok;
  assign box_we  = accept && (command_i == CMD_LOAD_BOX) && slot_ok;
  assign count_d = (32'(frames_in_use_q) > 32'(MAX_FRAMES)) ? CNTW'(MAX_FRAMES)
                                                            : CNTW'(frames_in_use_q);

  always_ff @(posedge clk_i) begin
    if (geo_we) begin
      geo_mem[wr_addr] <= {pixel_height_i, pixel_width_i, c_y_i, c_x_i, b_y_i, b_x_i,
                           a_y_i, a_x_i};
    end
    geo_rd_q <= geo_mem[n_q[FA-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (box_we) begin
      box_mem[wr_addr] <= {b_y_i, b_x_i, a_y_i, a_x_i};
    end
    box_rd_q <= box_mem[n_q[FA-1:0]];
  end

  // table entry fields
  logic signed [COORD_BITS-1:0] s_x, s_y, e_x, e_y, l_x, l_y, lo_x, lo_y, hi_x, hi_y;
  logic box_in;

  assign s_x  = geo_rd_q[0*COORD_BITS +: COORD_BITS];
  assign s_y  = geo_rd_q[1*COORD_BITS +: COORD_BITS];
  assign e_x  = geo_rd_q[2*COORD_BITS +: COORD_BITS];
  assign e_y  = geo_rd_q[3*COORD_BITS +: COORD_BITS];
  assign l_x  = geo_rd_q[4*COORD_BITS +: COORD_BITS];
  assign l_y  = geo_rd_q[5*COORD_BITS +: COORD_BITS];
  assign lo_x = box_rd_q[0*COORD_BITS +: COORD_BITS];
  assign lo_y = box_rd_q[1*COORD_BITS +: COORD_BITS];
  assign hi_x = box_rd_q[2*COORD_BITS +: COORD_BITS];
  assign hi_y = box_rd_q[3*COORD_BITS +: COORD_BITS];
  assign box_in = (lo_x <= qx_q) && (lo_y <= qy_q) && (qx_q <= hi_x) && (qy_q <= hi_y);

  // operand magnitudes and signs
  logic [CW1-1:0] mpx, mpy, mex, mey, mlx, mly;
  assign mpx = px_q[CW1-1] ? CW1'(-px_q) : CW1'(px_q);
  assign mpy = py_q[CW1-1] ? CW1'(-py_q) : CW1'(py_q);
  assign mex = ex_q[CW1-1] ? CW1'(-ex_q) : CW1'(ex_q);
  assign mey = ey_q[CW1-1] ? CW1'(-ey_q) : CW1'(ey_q);
  assign mlx = lx_q[CW1-1] ? CW1'(-lx_q) : CW1'(lx_q);
  assign mly = ly_q[CW1-1] ? CW1'(-ly_q) : CW1'(ly_q);

  logic [AW-1:0] op_a;
  logic [NW-1:0] op_b;
  logic          op_neg, op_keep;

  always_comb begin
    op_a    = '0;
    op_b    = '0;
    op_neg  = 1'b0;
    op_keep = 1'b0;
    unique case (op_q)
      OP_EXEX: begin op_a = AW'(mex); op_b = NW'(mex); end
      OP_EYEY: begin op_a = AW'(mey); op_b = NW'(mey); op_keep = 1'b1; end
      OP_LXLX: begin op_a = AW'(mlx); op_b = NW'(mlx); end
      OP_LYLY: begin op_a = AW'(mly); op_b = NW'(mly); op_keep = 1'b1; end
      OP_PXEX: begin
        op_a = AW'(mpx); op_b = NW'(mex); op_neg = px_q[CW1-1] ^ ex_q[CW1-1];
      end
      OP_PYEY: begin
        op_a = AW'(mpy); op_b = NW'(mey); op_neg = py_q[CW1-1] ^ ey_q[CW1-1];
        op_keep = 1'b1;
      end
      OP_PXEY: begin
        op_a = AW'(mpx); op_b = NW'(mey); op_neg = px_q[CW1-1] ^ ey_q[CW1-1];
      end
      // cross product subtracts this term
      OP_PYEX: begin
        op_a = AW'(mpy); op_b = NW'(mex); op_neg = ~(py_q[CW1-1] ^ ex_q[CW1-1]);
        op_keep = 1'b1;
      end
      OP_DOTW: begin op_a = AW'(dot_q); op_b = NW'(w_q); end
      OP_CRSH: begin op_a = AW'(crs_q); op_b = NW'(h_q); end
      OP_XX:   begin op_a = AW'(x_q);   op_b = x_q; end
      OP_L2H2: begin op_a = AW'(l2_q);  op_b = NW'(h2_q); end
      default: ;
    endcase
  end

  logic [AW-1:0] acc_abs;
  assign acc_abs = acc_q[AW-1] ? -acc_q : acc_q;

  // bisection, one quotient bit per trial, largest first
  logic [QW-1:0] trial, qb_val;
  logic [VW-1:0] trial_sq;
  logic          trial_over, trial_le, quot_step;
  logic [AW-1:0] quot_lim;

  assign trial      = q_q | (QW'(1) << k_q);
  assign trial_over = trial[QW-1] && (|trial[QW-2:0]);
  assign trial_sq   = VW'(trial) * VW'(trial);
  assign quot_lim   = (mode_q == MODE_ROW) ? AW'(nrow_q) : AW'(c_q);
  assign trial_le   = acc_q <= quot_lim;
  assign qb_val     = (state_q == ST_MUL && trial_le) ? trial : q_q;
  assign quot_step  = ((state_q == ST_MUL) && (mb_q == '0) && (mode_q != MODE_GEOM))
                   || ((state_q == ST_QSET) && trial_over);

  function automatic logic [PIXEL_BITS-1:0] sat(input logic [QW-1:0] v);
    sat = v[QW-1] ? '1 : v[PIXEL_BITS-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      frames_in_use_q <= '0;
      count_q         <= '0;
      n_q             <= '0;
      qx_q            <= '0;
      qy_q            <= '0;
      px_q            <= '0;
      py_q            <= '0;
      ex_q            <= '0;
      ey_q            <= '0;
      lx_q            <= '0;
      ly_q            <= '0;
      w_q             <= '0;
      h_q             <= '0;
      l2_q            <= '0;
      h2_q            <= '0;
      dot_q           <= '0;
      crs_q           <= '0;
      nrow_q          <= '0;
      x_q             <= '0;
      c_q             <= '0;
      m_q             <= '0;
      op_q            <= OP_EXEX;
      mode_q          <= MODE_GEOM;
      ma_q            <= '0;
      mb_q            <= '0;
      acc_q           <= '0;
      neg_q           <= 1'b0;
      q_q             <= '0;
      qr_q            <= '0;
      k_q             <= '0;
      found_q         <= 1'b0;
      hit_q           <= 1'b0;
      idx_q           <= '0;
      row_q           <= '0;
      col_q           <= '0;
    end else begin
      if (cfg_we_i) begin
        frames_in_use_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept && command_i == CMD_QUERY) begin
            qx_q    <= a_x_i;
            qy_q    <= a_y_i;
            count_q <= count_d;
            n_q     <= '0;
            found_q <= 1'b0;
            hit_q   <= 1'b0;
            idx_q   <= '0;
            row_q   <= '0;
            col_q   <= '0;
            state_q <= (count_d == '0) ? ST_DONE : ST_READ;
          end
        end
        ST_READ: state_q <= ST_CHECK;
        ST_CHECK: begin
          if (box_in) begin
            hit_q   <= 1'b1;
            idx_q   <= n_q;
            px_q    <= CW1'(qx_q) - CW1'(s_x);
            py_q    <= CW1'(qy_q) - CW1'(s_y);
            ex_q    <= CW1'(e_x) - CW1'(s_x);
            ey_q    <= CW1'(e_y) - CW1'(s_y);
            lx_q    <= CW1'(l_x) - CW1'(s_x);
            ly_q    <= CW1'(l_y) - CW1'(s_y);
            w_q     <= geo_rd_q[6*COORD_BITS +: PIXEL_BITS];
            h_q     <= geo_rd_q[6*COORD_BITS+PIXEL_BITS +: PIXEL_BITS];
            op_q    <= OP_EXEX;
            mode_q  <= MODE_GEOM;
            state_q <= ST_SET;
          end else begin
            state_q <= ST_NEXT;
          end
        end
        ST_SET: begin
          ma_q    <= op_a;
          mb_q    <= op_b;
          neg_q   <= op_neg;
          acc_q   <= op_keep ? acc_q : '0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          if (mb_q != '0) begin
            if (mb_q[0]) begin
              acc_q <= neg_q ? acc_q - ma_q : acc_q + ma_q;
            end
            ma_q <= ma_q << 1;
            mb_q <= mb_q >> 1;
          end else if (mode_q == MODE_GEOM) begin
            case (op_q)
              OP_EYEY: l2_q   <= acc_q[DW-1:0];
              OP_LYLY: h2_q   <= acc_q[DW-1:0];
              OP_PYEY: dot_q  <= acc_abs[DW-1:0];
              OP_PYEX: crs_q  <= acc_abs[DW-1:0];
              OP_DOTW: nrow_q <= acc_q[NW-1:0];
              OP_CRSH: x_q    <= acc_q[NW-1:0];
              OP_XX:   c_q    <= acc_q[PW-1:0];
              OP_L2H2: m_q    <= acc_q[PW-1:0];
              default: ;
            endcase
            // zero-length upper or left edge: skip to the next frame, nothing computed
            if (op_q == OP_LYLY && (l2_q == '0 || acc_q[DW-1:0] == '0)) begin
              state_q <= ST_NEXT;
            end else if (op_q == OP_L2H2) begin
              mode_q  <= MODE_ROW;
              q_q     <= '0;
              k_q     <= KW'(PIXEL_BITS);
              state_q <= ST_QSET;
            end else begin
              op_q    <= op_q + 4'd1;
              state_q <= ST_SET;
            end
          end
        end
        ST_QSET: begin
          if (!trial_over) begin
            ma_q    <= (mode_q == MODE_ROW) ? AW'(l2_q) : AW'(m_q);
            mb_q    <= (mode_q == MODE_ROW) ? NW'(trial) : NW'(trial_sq);
            neg_q   <= 1'b0;
            acc_q   <= '0;
            state_q <= ST_MUL;
          end
        end
        ST_NEXT: begin
          if (CNTW'(n_q + 1'b1) == count_q) begin
            state_q <= ST_DONE;
          end else begin
            n_q     <= CNTW'(n_q + 1'b1);
            state_q <= ST_READ;
          end
        end
        ST_DONE: state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase

      // end of one bisection trial
      if (quot_step) begin
        q_q <= qb_val;
        if (k_q != '0) begin
          k_q     <= k_q - 1'b1;
          state_q <= ST_QSET;
        end else if (mode_q == MODE_ROW) begin
          qr_q    <= qb_val;
          mode_q  <= MODE_COL;
          q_q     <= '0;
          k_q     <= KW'(PIXEL_BITS);
          state_q <= ST_QSET;
        end else begin
          row_q <= sat(qr_q);
          col_q <= sat(qb_val);
          if (qr_q < QW'(w_q) && qb_val < QW'(h_q)) begin
            found_q <= 1'b1;
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_NEXT;
          end
        end
      end
    end
  end

  assign busy_o        = state_q != ST_IDLE;
  assign done_o        = state_q == ST_DONE;
  assign found_o       = found_q;
  assign box_hit_o     = hit_q;
  assign frame_index_o = 10'(idx_q);
  assign row_o         = row_q;
  assign col_o         = col_q;

  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy_o)
    else $error("result beat longer than one cycle");

  a_found_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && found_o |-> box_hit_o)
    else $error("found without a box hit");

  a_no_hit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !box_hit_o |-> frame_index_o == '0 && row_o == '0 && col_o == '0)
    else $error("miss result carries frame data");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && command_i == CMD_QUERY |=> busy_o)
    else $error("query accepted but block not busy");

  a_trial_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL && mode_q != MODE_GEOM |-> !trial_over)
    else $error("bisection trial above limit reached the multiplier");

endmodule
